// ----- rtl/swrl_pkg.sv -----
// shared constants and types of the per-key sliding-window rate limiter
package swrl_pkg;

   // table geometry
   localparam int NUM_SLOTS  = 256;
   localparam int SLOT_BITS  = $clog2(NUM_SLOTS);
   localparam int MAX_STAMPS = 8;
   localparam int HEAD_BITS  = $clog2(MAX_STAMPS);
   localparam int COUNT_BITS = $clog2(MAX_STAMPS + 1);
   localparam int TIME_BITS  = 32;
   localparam int ADDR_BITS  = SLOT_BITS + HEAD_BITS;
   localparam int META_BITS  = HEAD_BITS + COUNT_BITS;

   // configuration registers
   localparam int CFG_BITS      = 32;
   localparam int CFG_IDX_BITS  = 1;
   localparam int MAX_CFG_BITS  = 4;
   localparam int WIN_CFG_BITS  = 32;
   localparam logic [CFG_IDX_BITS-1:0] REG_MAX_PER_WINDOW = 1'd0;
   localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW_TICKS   = 1'd1;
   localparam logic [MAX_CFG_BITS-1:0] MAX_PER_WINDOW_RST = 4'd5;
   localparam logic [WIN_CFG_BITS-1:0] WINDOW_TICKS_RST   = 32'd1000;

   // stream payload widths
   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 8;

   // controller to datapath commands
   typedef struct packed {
      logic load_req;
      logic load_meta;
      logic expire_step;
      logic commit;
   } swrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic ring_empty;
      logic stamp_old;
      logic out_full;
   } swrl_sts_type;

endpackage

// ----- rtl/per_key_sliding_window_rate_limiter_unit.sv -----
// top level of the per-key sliding-window rate limiter
//
// each request names a key slot and a timestamp; the slot keeps a ring of up
// to eight accepted stamps. stamps older than the window leave the ring head,
// then the request is allowed if fewer than max_per_window stamps remain, and
// an allowed stamp is appended at the tail.
// req channel: one transaction per request; rsp channel: one transaction with
// the decision and the count in the window before the append.
// csr port: index 0 max_per_window, index 1 window_ticks; write while idle.
// timing: one request at a time; each request passes the idle, meta, scan and
// decide states in that order, and the scan over the slot's stamp memory reads
// one stamp per cycle while the stamps at the ring head expire.
// a result waiting in the rsp register does not block the next request; that
// request only holds at its decision while the rsp side stalls.
// reset empties every ring at once and restores the register defaults
// (limit 5, window 1000 ticks).
module per_key_sliding_window_rate_limiter_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [swrl_pkg::REQ_DATA_BITS-1:0] req_tdata,  // key_slot[7:0], now_ticks[39:8]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [swrl_pkg::RSP_DATA_BITS-1:0] rsp_tdata,  // allowed[0], in_window[4:1], zero[7:5]
   input  logic                               csr_wr_en,
   input  logic [swrl_pkg::CFG_IDX_BITS-1:0]  csr_index,
   input  logic [swrl_pkg::CFG_BITS-1:0]      csr_wr_data
);

   swrl_pkg::swrl_cmd_type cmd;
   swrl_pkg::swrl_sts_type sts;

   // sequencer
   swrl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // tables, compare and result
   swrl_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// ----- rtl/swrl_ctrl.sv -----
// controller state machine: accept, ring lookup, expiry scan, decision
module swrl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  swrl_pkg::swrl_sts_type sts,
   output swrl_pkg::swrl_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_META   = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_DECIDE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // next state and commands
   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      req_tready      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = !reset;
            if (req_tvalid && !reset) begin
               cmd.load_req = 1'b1;
               state_in     = ST_META;
            end
         end
         ST_META: begin
            cmd.load_meta = 1'b1;
            state_in      = ST_SCAN;
         end
         ST_SCAN: begin
            if (!sts.ring_empty && sts.stamp_old) begin
               cmd.expire_step = 1'b1;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!sts.out_full) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/swrl_dp.sv -----
// datapath: ring tables, stamp memory, expiry compare, decision and result register
module swrl_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [swrl_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  logic                                 csr_wr_en,
   input  logic [swrl_pkg::CFG_IDX_BITS-1:0]    csr_index,
   input  logic [swrl_pkg::CFG_BITS-1:0]        csr_wr_data,
   input  swrl_pkg::swrl_cmd_type               cmd,
   output swrl_pkg::swrl_sts_type               sts,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [swrl_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);

   localparam int SB = swrl_pkg::SLOT_BITS;
   localparam int HB = swrl_pkg::HEAD_BITS;
   localparam int CB = swrl_pkg::COUNT_BITS;
   localparam int TB = swrl_pkg::TIME_BITS;

   // configuration
   logic [swrl_pkg::MAX_CFG_BITS-1:0] max_ff;
   logic [swrl_pkg::WIN_CFG_BITS-1:0] window_ff;

   // transaction in flight
   logic [SB-1:0] key_ff;
   logic [TB-1:0] now_ff;
   logic [HB-1:0] head_ff;
   logic [CB-1:0] count_ff;

   // memories and their read registers
   logic [TB-1:0]                      stamp_mem_ff [swrl_pkg::NUM_SLOTS*swrl_pkg::MAX_STAMPS];
   logic [TB-1:0]                      stamp_rd_ff;
   logic [swrl_pkg::META_BITS-1:0]     meta_mem_ff [swrl_pkg::NUM_SLOTS];
   logic [swrl_pkg::META_BITS-1:0]     meta_rd_ff;
   logic [swrl_pkg::NUM_SLOTS-1:0]     meta_vld_ff;
   logic                               meta_vld_rd_ff;

   // result register
   logic                               rsp_valid_ff;
   logic [swrl_pkg::RSP_DATA_BITS-1:0] rsp_data_ff;

   logic [SB-1:0] req_key;
   logic [HB-1:0] meta_head;
   logic [CB-1:0] meta_count;
   logic [CB-1:0] meta_count_raw;
   logic [HB-1:0] rd_head;
   logic [TB-1:0] age;
   logic [CB-1:0] limit;
   logic          allow;
   logic [HB-1:0] tail;
   logic [CB-1:0] count_next;

   assign req_key = req_tdata[SB-1:0];

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff    <= swrl_pkg::MAX_PER_WINDOW_RST;
         window_ff <= swrl_pkg::WINDOW_TICKS_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            swrl_pkg::REG_MAX_PER_WINDOW: max_ff    <= csr_wr_data[swrl_pkg::MAX_CFG_BITS-1:0];
            swrl_pkg::REG_WINDOW_TICKS:   window_ff <= csr_wr_data[swrl_pkg::WIN_CFG_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ring state of the slot, empty where never written
   assign meta_count_raw = meta_vld_rd_ff ? meta_rd_ff[CB-1:0] : '0;
   assign meta_head      = meta_vld_rd_ff ? meta_rd_ff[swrl_pkg::META_BITS-1:CB] : '0;
   assign meta_count     = (meta_count_raw > CB'(swrl_pkg::MAX_STAMPS)) ?
                           CB'(swrl_pkg::MAX_STAMPS) : meta_count_raw;

   // stamp read address: ring head on lookup, next head while expiring
   assign rd_head = cmd.load_meta ? meta_head : HB'(head_ff + 1'b1);

   // expiry compare by modular difference
   assign age = now_ff - stamp_rd_ff;

   // decision
   assign limit      = (max_ff > CB'(swrl_pkg::MAX_STAMPS)) ?
                       CB'(swrl_pkg::MAX_STAMPS) : max_ff;
   assign allow      = count_ff < limit;
   assign tail       = head_ff + count_ff[HB-1:0];
   assign count_next = allow ? CB'(count_ff + 1'b1) : count_ff;

   assign sts.ring_empty = (count_ff == '0);
   assign sts.stamp_old  = (age > window_ff);
   assign sts.out_full   = rsp_valid_ff && !rsp_tready;

   // transaction registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         key_ff <= req_key;
         now_ff <= req_tdata[SB+TB-1:SB];
      end
      if (cmd.load_meta) begin
         head_ff  <= meta_head;
         count_ff <= meta_count;
      end else if (cmd.expire_step) begin
         head_ff  <= HB'(head_ff + 1'b1);
         count_ff <= CB'(count_ff - 1'b1);
      end
   end

   // stamp memory
   always_ff @(posedge clock) begin
      stamp_rd_ff <= stamp_mem_ff[{key_ff, rd_head}];
      if (cmd.commit && allow) begin
         stamp_mem_ff[{key_ff, tail}] <= now_ff;
      end
   end

   // ring head and count memory
   always_ff @(posedge clock) begin
      meta_rd_ff <= meta_mem_ff[req_key];
      if (cmd.commit) begin
         meta_mem_ff[key_ff] <= {head_ff, count_next};
      end
   end

   // written flags of the ring table
   always_ff @(posedge clock) begin
      if (reset) begin
         meta_vld_ff <= '0;
      end else if (cmd.commit) begin
         meta_vld_ff[key_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      meta_vld_rd_ff <= meta_vld_ff[req_key];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= swrl_pkg::RSP_DATA_BITS'({count_ff, allow});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
